// ----- sv/oeg_pkg.sv -----
// ----------------------------------------------------------------------------
// oeg_pkg
// shared widths, pair tables and stage control type of the orthogonality block
// ----------------------------------------------------------------------------
`default_nettype none

package oeg_pkg;

    localparam int AW    = 32;
    localparam int KvW   = 64;
    localparam int TermW = 36;
    localparam int DotW  = 38;
    localparam int SqW   = 51;
    localparam int GtW   = 46;
    localparam int InnW  = 48;
    localparam int ValW  = 52;
    localparam int ResW  = 64;
    localparam int NPair = 6;
    localparam int NOut  = 10;

    localparam logic signed [DotW-1:0] OneQ28 = {{(DotW-29){1'b0}}, 1'b1, {28{1'b0}}};

    typedef struct packed {
        logic load_a;
        logic load_b;
    } t_adv;

    function automatic int pair_i(input int p);
        int r;
        case (p)
            0: r = 0;
            1: r = 1;
            2: r = 2;
            3: r = 0;
            4: r = 1;
            default: r = 0;
        endcase
        return r;
    endfunction

    function automatic int pair_j(input int p);
        int r;
        case (p)
            0: r = 0;
            1: r = 1;
            2: r = 2;
            3: r = 1;
            4: r = 2;
            default: r = 2;
        endcase
        return r;
    endfunction

    function automatic int pair_of(input int i, input int j);
        int r;
        if (i == j) begin
            r = i;
        end else if ((i + j) == 1) begin
            r = 3;
        end else if ((i + j) == 3) begin
            r = 4;
        end else begin
            r = 5;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/orthogonality_energy_gradient_top.sv -----
// ----------------------------------------------------------------------------
// orthogonality_energy_gradient_top
// orthogonality energy and gradient of one affine body per beat
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready, one beat carries stiffness, volume and the
// three affine vectors. output channel: o_valid / i_ready, one beat carries
// the energy and the nine gradient entries.
// six register stages: products of the dot terms, dot sums, squares and
// gradient terms, sums, kv partial products, shift and saturate into the
// output register. throughput is one body per cycle while the receiver
// accepts; every stage holds a valid bit and each stage loads when it is
// empty or the stage behind it moves.
// when the receiver stalls, the output register holds its beat and the
// stages fill up one by one; o_ready falls only when all six are full.
// synchronous reset clears the valid bits only; no state spans beats.
// ----------------------------------------------------------------------------
`default_nettype none

module orthogonality_energy_gradient_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [31:0]        i_stiffness,
    input  wire logic [31:0]        i_volume,
    input  wire logic signed [31:0] i_col1_x,
    input  wire logic signed [31:0] i_col1_y,
    input  wire logic signed [31:0] i_col1_z,
    input  wire logic signed [31:0] i_col2_x,
    input  wire logic signed [31:0] i_col2_y,
    input  wire logic signed [31:0] i_col2_z,
    input  wire logic signed [31:0] i_col3_x,
    input  wire logic signed [31:0] i_col3_y,
    input  wire logic signed [31:0] i_col3_z,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [62:0]             o_energy,
    output logic signed [63:0]      o_grad1_x,
    output logic signed [63:0]      o_grad1_y,
    output logic signed [63:0]      o_grad1_z,
    output logic signed [63:0]      o_grad2_x,
    output logic signed [63:0]      o_grad2_y,
    output logic signed [63:0]      o_grad2_z,
    output logic signed [63:0]      o_grad3_x,
    output logic signed [63:0]      o_grad3_y,
    output logic signed [63:0]      o_grad3_z
);

    localparam int AW    = oeg_pkg::AW;
    localparam int KvW   = oeg_pkg::KvW;
    localparam int TermW = oeg_pkg::TermW;
    localparam int DotW  = oeg_pkg::DotW;
    localparam int SqW   = oeg_pkg::SqW;
    localparam int GtW   = oeg_pkg::GtW;
    localparam int InnW  = oeg_pkg::InnW;
    localparam int ValW  = oeg_pkg::ValW;
    localparam int ResW  = oeg_pkg::ResW;
    localparam int NPair = oeg_pkg::NPair;
    localparam int NOut  = oeg_pkg::NOut;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;

    logic signed [AW-1:0]    w_a  [0:2][0:2];
    logic signed [AW-1:0]    r_a1 [0:2][0:2];
    logic signed [AW-1:0]    r_a2 [0:2][0:2];
    logic [KvW-1:0]          r_kv1, r_kv2, r_kv3, r_kv4;
    logic signed [TermW-1:0] r_t1 [0:NPair-1][0:2];
    logic signed [TermW-1:0] n_t1 [0:NPair-1][0:2];
    logic signed [DotW-1:0]  r_d2 [0:NPair-1];
    logic signed [DotW-1:0]  n_d2 [0:NPair-1];
    logic [SqW-1:0]          r_sq3 [0:NPair-1];
    logic [SqW-1:0]          n_sq3 [0:NPair-1];
    logic signed [GtW-1:0]   r_g3 [0:2][0:2][0:2];
    logic signed [GtW-1:0]   n_g3 [0:2][0:2][0:2];
    logic signed [ValW-1:0]  r_val4 [0:NOut-1];
    logic signed [ValW-1:0]  n_val4 [0:NOut-1];
    logic signed [ResW-1:0]  w_res [0:NOut-1];
    oeg_pkg::t_adv           w_adv;

    assign w_a[0][0] = i_col1_x;
    assign w_a[0][1] = i_col1_y;
    assign w_a[0][2] = i_col1_z;
    assign w_a[1][0] = i_col2_x;
    assign w_a[1][1] = i_col2_y;
    assign w_a[1][2] = i_col2_z;
    assign w_a[2][0] = i_col3_x;
    assign w_a[2][1] = i_col3_y;
    assign w_a[2][2] = i_col3_z;

    // stall chain
    assign w_rdy6 = !r_v6 || i_ready;
    assign w_rdy5 = !r_v5 || w_rdy6;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v6;

    assign w_adv.load_a = w_rdy5 && r_v4;
    assign w_adv.load_b = w_rdy6 && r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
            if (w_rdy6) begin
                r_v6 <= r_v5;
            end
        end
    end

    // stage 1: component products floored to q.28
    always_comb begin
        logic signed [63:0] prod;
        for (int p = 0; p < NPair; p++) begin
            for (int c = 0; c < 3; c++) begin
                prod = w_a[oeg_pkg::pair_i(p)][c] * w_a[oeg_pkg::pair_j(p)][c];
                n_t1[p][c] = prod[63:28];
            end
        end
    end

    // stage 2: dot sums, diagonal minus one
    always_comb begin
        logic signed [DotW-1:0] d;
        for (int p = 0; p < NPair; p++) begin
            d = DotW'(r_t1[p][0]) + DotW'(r_t1[p][1]) + DotW'(r_t1[p][2]);
            if (p < 3) begin
                n_d2[p] = d - oeg_pkg::OneQ28;
            end else begin
                n_d2[p] = d;
            end
        end
    end

    // stage 3: squares and gradient terms floored to q.32
    always_comb begin
        logic signed [75:0] sq;
        logic signed [69:0] gp;
        for (int p = 0; p < NPair; p++) begin
            sq = r_d2[p] * r_d2[p];
            n_sq3[p] = sq[SqW+23:24];
        end
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 3; j++) begin
                    gp = r_d2[oeg_pkg::pair_of(i, j)] * r_a2[j][c];
                    n_g3[i][c][j] = gp[69:24];
                end
            end
        end
    end

    // stage 4: energy sum and gradient inner sums
    always_comb begin
        logic [SqW+1:0] vs;
        logic signed [InnW-1:0] inn;
        vs = (SqW+2)'(r_sq3[0]) + (SqW+2)'(r_sq3[1]) + (SqW+2)'(r_sq3[2])
           + (((SqW+2)'(r_sq3[3]) + (SqW+2)'(r_sq3[4]) + (SqW+2)'(r_sq3[5])) << 1);
        n_val4[0] = $signed({1'b0, vs[SqW-1:0]});
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                inn = InnW'(r_g3[i][c][0]) + InnW'(r_g3[i][c][1]) + InnW'(r_g3[i][c][2]);
                n_val4[1 + i * 3 + c] = ValW'($signed({inn, 2'b00}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_kv1 <= KvW'(i_stiffness) * KvW'(i_volume);
            r_a1  <= w_a;
            r_t1  <= n_t1;
        end
        if (w_rdy2 && r_v1) begin
            r_kv2 <= r_kv1;
            r_a2  <= r_a1;
            r_d2  <= n_d2;
        end
        if (w_rdy3 && r_v2) begin
            r_kv3 <= r_kv2;
            r_sq3 <= n_sq3;
            r_g3  <= n_g3;
        end
        if (w_rdy4 && r_v3) begin
            r_kv4  <= r_kv3;
            r_val4 <= n_val4;
        end
    end

    // stages 5 and 6: kv scaling
    for (genvar k = 0; k < NOut; k++) begin : g_scale
        oeg_scale u_scale (
            .i_clk (i_clk),
            .i_adv (w_adv),
            .i_kv  (r_kv4),
            .i_val (r_val4[k]),
            .o_res (w_res[k])
        );
    end

    assign o_energy  = w_res[0][ResW-2:0];
    assign o_grad1_x = w_res[1];
    assign o_grad1_y = w_res[2];
    assign o_grad1_z = w_res[3];
    assign o_grad2_x = w_res[4];
    assign o_grad2_y = w_res[5];
    assign o_grad2_z = w_res[6];
    assign o_grad3_x = w_res[7];
    assign o_grad3_y = w_res[8];
    assign o_grad3_z = w_res[9];

endmodule

`default_nettype wire

// ----- sv/oeg_scale.sv -----
// ----------------------------------------------------------------------------
// oeg_scale
// kv times signed value over two stages, floored by 2^32 and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module oeg_scale (
    input  wire logic                              i_clk,
    input  wire oeg_pkg::t_adv                     i_adv,
    input  wire logic [oeg_pkg::KvW-1:0]           i_kv,
    input  wire logic signed [oeg_pkg::ValW-1:0]   i_val,
    output logic signed [oeg_pkg::ResW-1:0]        o_res
);

    localparam int SumW = 120;
    localparam logic signed [SumW-1:0] SatMax = $signed({{(SumW-63){1'b0}}, {63{1'b1}}});
    localparam logic signed [SumW-1:0] SatMin = $signed({{(SumW-63){1'b1}}, {63{1'b0}}});

    logic signed [59:0] r_pll, r_phl;
    logic signed [58:0] r_plh, r_phh;
    logic signed [SumW-1:0] w_sum, w_q;
    logic signed [oeg_pkg::ResW-1:0] n_res;

    always_ff @(posedge i_clk) begin
        if (i_adv.load_a) begin
            r_pll <= $signed({1'b0, i_kv[31:0]}) * $signed({1'b0, i_val[25:0]});
            r_plh <= $signed({1'b0, i_kv[31:0]}) * $signed(i_val[51:26]);
            r_phl <= $signed({1'b0, i_kv[63:32]}) * $signed({1'b0, i_val[25:0]});
            r_phh <= $signed({1'b0, i_kv[63:32]}) * $signed(i_val[51:26]);
        end
        if (i_adv.load_b) begin
            o_res <= n_res;
        end
    end

    always_comb begin
        w_sum = SumW'(r_pll) + (SumW'(r_plh) <<< 26) + (SumW'(r_phl) <<< 32)
              + (SumW'(r_phh) <<< 58);
        w_q = w_sum >>> 32;
        if (w_q > SatMax) begin
            n_res = {1'b0, {(oeg_pkg::ResW-1){1'b1}}};
        end else if (w_q < SatMin) begin
            n_res = {1'b1, {(oeg_pkg::ResW-1){1'b0}}};
        end else begin
            n_res = w_q[oeg_pkg::ResW-1:0];
        end
    end

endmodule

`default_nettype wire
